### sv/i2c_master_byte_engine_assert.svh
// Assertion macros used by the checker file of the byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

### sv/i2cm_pkg.sv
// Types and phase constants of the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_e;

  // Position inside one write bit: data setup, clock high, clock low.
  typedef enum logic [1:0] {
    SLOT_DATA = 2'd0,
    SLOT_HIGH = 2'd1,
    SLOT_LOW  = 2'd2
  } slot_e;

  typedef struct packed {
    kind_e      kind;
    op_e        cmd;
    logic [7:0] data;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       rejected;
  } result_t;

  localparam int unsigned PhaseW = 5;

  localparam logic [PhaseW-1:0] StopDataLow   = 5'd1;
  localparam logic [PhaseW-1:0] StopClkHigh   = 5'd2;
  localparam logic [PhaseW-1:0] StartDataHigh = 5'd1;
  localparam logic [PhaseW-1:0] StartClkHigh  = 5'd2;
  localparam logic [PhaseW-1:0] StartDataLow  = 5'd3;
  localparam logic [PhaseW-1:0] WrBitsEnd     = 5'd24;
  localparam logic [PhaseW-1:0] WrAckRelease  = 5'd25;
  localparam logic [PhaseW-1:0] WrAckHigh     = 5'd26;
  localparam logic [PhaseW-1:0] RdRelease     = 5'd1;
  localparam logic [PhaseW-1:0] RdBitsEnd     = 5'd18;
  localparam logic [PhaseW-1:0] RdFirstSample = 5'd4;
  localparam logic [PhaseW-1:0] RdAckDrive    = 5'd19;
  localparam logic [PhaseW-1:0] RdAckHigh     = 5'd20;

endpackage

`default_nettype wire

### sv/i2cm_if.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none

interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;
  logic       sda_in;

  modport source (output valid, output op, output data_byte, output sda_in, input ready);
  modport sink   (input valid, input op, input data_byte, input sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_ok;
  logic       rejected;

  modport source (output valid, output scl, output sda_release, output busy_res,
                  output done_res, output rx_byte, output ack_ok, output rejected,
                  input ready);
  modport sink   (input valid, input scl, input sda_release, input busy_res,
                  input done_res, input rx_byte, input ack_ok, input rejected,
                  output ready);
endinterface

`default_nettype wire

### sv/i2c_master_byte_engine.sv
// A result word is registered after its command word has passed through the queue.
// Throughput: one word per cycle while output is ready; one sequencer step per word.
// While output stalls the queue absorbs QueueDepth words and the result register
// one more; after that input stalls. Reset (rst_ni low, asynchronous): queue and
// result register empty, sequencer idle, SCL and SDA released, shift register and
// ack flag cleared.
`default_nettype none

module i2c_master_byte_engine #(
  // Queue depth between classifier and sequencer; at least 2.
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2cm_cmd_if.sink   in_i,
  i2cm_res_if.source out_o
);

  // Queue head handed from the front end to the sequencer.
  i2cm_pkg::item_t head;
  logic            head_valid;
  logic            pop;

  // Front end: accept command words, turn the raw op code into a kind
  // (tick, command, or no-op for codes that mean nothing) and buffer them.
  i2cm_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (in_i),
    .head_o      (head),
    .head_valid_o(head_valid),
    .pop_i       (pop)
  );

  // Back end: one step of the start, stop, write or read sequence per tick
  // word, rejection of commands while a sequence runs, and the result
  // register that drives the output channel.
  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .res_o       (out_o)
  );

endmodule

`default_nettype wire

### sv/i2cm_front.sv
// Front end: classifies command words and holds them in a small queue.
`default_nettype none

module i2cm_front #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  i2cm_cmd_if.sink            cmd_i,
  output i2cm_pkg::item_t     head_o,
  output logic                head_valid_o,
  input  wire logic           pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cm_pkg::item_t item_in;
  i2cm_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  // Classify the raw op code; codes without meaning become no-ops.
  always_comb begin
    item_in.data = cmd_i.data_byte;
    item_in.sda  = cmd_i.sda_in;
    item_in.cmd  = i2cm_pkg::OP_TICK;
    case (cmd_i.op)
      i2cm_pkg::OP_TICK: begin
        item_in.kind = i2cm_pkg::KIND_TICK;
      end
      i2cm_pkg::OP_START: begin
        item_in.kind = i2cm_pkg::KIND_CMD;
        item_in.cmd  = i2cm_pkg::OP_START;
      end
      i2cm_pkg::OP_STOP: begin
        item_in.kind = i2cm_pkg::KIND_CMD;
        item_in.cmd  = i2cm_pkg::OP_STOP;
      end
      i2cm_pkg::OP_WRITE: begin
        item_in.kind = i2cm_pkg::KIND_CMD;
        item_in.cmd  = i2cm_pkg::OP_WRITE;
      end
      i2cm_pkg::OP_READ_ACK: begin
        item_in.kind = i2cm_pkg::KIND_CMD;
        item_in.cmd  = i2cm_pkg::OP_READ_ACK;
      end
      i2cm_pkg::OP_READ_NACK: begin
        item_in.kind = i2cm_pkg::KIND_CMD;
        item_in.cmd  = i2cm_pkg::OP_READ_NACK;
      end
      default: begin
        item_in.kind = i2cm_pkg::KIND_NOP;
      end
    endcase
  end

  assign cmd_i.ready  = (count_q != CntW'(Depth));
  assign push         = cmd_i.valid && cmd_i.ready;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

### sv/i2cm_back.sv
// Back end: the bit sequencer and the result word register.
`default_nettype none

module i2cm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire i2cm_pkg::item_t head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  i2cm_res_if.source          res_o
);

  i2cm_pkg::op_e                   cmd_q, cmd_d;
  logic [i2cm_pkg::PhaseW-1:0]     phase_q, phase_d, p;
  i2cm_pkg::slot_e                 slot_q, slot_d;
  logic [7:0]                      shift_q, shift_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            ack_q, ack_d;
  logic                            fin;
  i2cm_pkg::result_t               res_d, res_q;
  logic                            out_valid_q;

  // Take the next word whenever the result register is free or drains.
  assign pop_o = head_valid_i && (!out_valid_q || res_o.ready);
  assign p     = phase_q + 1'b1;

  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    slot_d  = slot_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    fin     = 1'b0;
    res_d   = '0;

    if (pop_o) begin
      case (head_i.kind)
        i2cm_pkg::KIND_CMD: begin
          if (cmd_q != i2cm_pkg::OP_TICK) begin
            res_d.rejected = 1'b1;
          end else begin
            cmd_d   = head_i.cmd;
            phase_d = '0;
            slot_d  = i2cm_pkg::SLOT_DATA;
            shift_d = (head_i.cmd == i2cm_pkg::OP_WRITE) ? head_i.data : 8'h00;
          end
        end
        i2cm_pkg::KIND_TICK: begin
          if (cmd_q != i2cm_pkg::OP_TICK) begin
            phase_d = p;
            case (cmd_q)
              i2cm_pkg::OP_START: begin
                if (p == i2cm_pkg::StartDataHigh) begin
                  sda_d = 1'b1;
                end else if (p == i2cm_pkg::StartClkHigh) begin
                  scl_d = 1'b1;
                end else if (p == i2cm_pkg::StartDataLow) begin
                  sda_d = 1'b0;
                end else begin
                  scl_d = 1'b0;
                  fin   = 1'b1;
                end
              end
              i2cm_pkg::OP_STOP: begin
                if (p == i2cm_pkg::StopDataLow) begin
                  sda_d = 1'b0;
                end else if (p == i2cm_pkg::StopClkHigh) begin
                  scl_d = 1'b1;
                end else begin
                  sda_d = 1'b1;
                  fin   = 1'b1;
                end
              end
              i2cm_pkg::OP_WRITE: begin
                if (p <= i2cm_pkg::WrBitsEnd) begin
                  case (slot_q)
                    i2cm_pkg::SLOT_DATA: begin
                      sda_d   = shift_q[7];
                      shift_d = {shift_q[6:0], 1'b0};
                      slot_d  = i2cm_pkg::SLOT_HIGH;
                    end
                    i2cm_pkg::SLOT_HIGH: begin
                      scl_d  = 1'b1;
                      slot_d = i2cm_pkg::SLOT_LOW;
                    end
                    default: begin
                      scl_d  = 1'b0;
                      slot_d = i2cm_pkg::SLOT_DATA;
                    end
                  endcase
                end else if (p == i2cm_pkg::WrAckRelease) begin
                  sda_d = 1'b1;
                end else if (p == i2cm_pkg::WrAckHigh) begin
                  scl_d = 1'b1;
                end else begin
                  ack_d = !head_i.sda;
                  scl_d = 1'b0;
                  fin   = 1'b1;
                end
              end
              i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
                if (p == i2cm_pkg::RdRelease) begin
                  sda_d = 1'b1;
                end else if (p <= i2cm_pkg::RdBitsEnd) begin
                  if (!p[0]) begin
                    scl_d = 1'b0;
                    if (p >= i2cm_pkg::RdFirstSample) begin
                      shift_d = {shift_q[6:0], head_i.sda};
                    end
                  end else begin
                    scl_d = 1'b1;
                  end
                end else if (p == i2cm_pkg::RdAckDrive) begin
                  sda_d = (cmd_q != i2cm_pkg::OP_READ_ACK);
                end else if (p == i2cm_pkg::RdAckHigh) begin
                  scl_d = 1'b1;
                end else begin
                  scl_d = 1'b0;
                  fin   = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      res_d.done_res = 1'b1;
      if (cmd_q == i2cm_pkg::OP_WRITE) begin
        res_d.ack_ok = ack_d;
      end
      if (cmd_q == i2cm_pkg::OP_READ_ACK || cmd_q == i2cm_pkg::OP_READ_NACK) begin
        res_d.rx_byte = shift_d;
      end
      cmd_d   = i2cm_pkg::OP_TICK;
      phase_d = '0;
    end

    res_d.scl         = scl_d;
    res_d.sda_release = sda_d;
    res_d.busy_res    = (cmd_d != i2cm_pkg::OP_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= i2cm_pkg::OP_TICK;
      phase_q     <= '0;
      slot_q      <= i2cm_pkg::SLOT_DATA;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      slot_q  <= slot_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.scl         = res_q.scl;
  assign res_o.sda_release = res_q.sda_release;
  assign res_o.busy_res    = res_q.busy_res;
  assign res_o.done_res    = res_q.done_res;
  assign res_o.rx_byte     = res_q.rx_byte;
  assign res_o.ack_ok      = res_q.ack_ok;
  assign res_o.rejected    = res_q.rejected;

endmodule

`default_nettype wire

### sv/i2cm_checker.sv
// Port-level checker for the byte engine and its bind statement.
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic [7:0] rx_byte_i,
  input wire logic       ack_ok_i,
  input wire logic       rejected_i
);

  // A finished sequence leaves the engine idle.
  `I2CM_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, out_valid_i && done_i, !busy_i)
  // A command is only refused while a sequence runs, and it keeps running.
  `I2CM_ASSERT_IMPL(a_reject_busy, clk_i, rst_ni, out_valid_i && rejected_i, busy_i)
  // Received data and ack appear only on the finishing word.
  `I2CM_ASSERT_IMPL(a_data_on_done, clk_i, rst_ni,
                    out_valid_i && (rx_byte_i != 8'h00 || ack_ok_i), done_i)
  // Hold a result word until it is taken.
  `I2CM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .busy_i     (out_o.busy_res),
  .done_i     (out_o.done_res),
  .rx_byte_i  (out_o.rx_byte),
  .ack_ok_i   (out_o.ack_ok),
  .rejected_i (out_o.rejected)
);

`default_nettype wire

### sim/tb_i2c_master_byte_engine.sv
// Self-checking testbench of the I2C master byte engine: directed and random word traffic.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;

  // Op codes outside the command set; the block must ignore them.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Sources of the sda_in bit while ticking a command through.
  localparam int unsigned SDA_LOW  = 0;
  localparam int unsigned SDA_HIGH = 1;
  localparam int unsigned SDA_RAND = 2;

  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned HangLimit = 3000;
  // Long hold-off of the result side used to fill the block.
  localparam int unsigned LongHold  = 300;

  logic clk_i;
  logic rst_ni;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();

  i2c_master_byte_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Bit sequencer shadow: line levels, phase and shift register of the engine.
  // OP_TICK in line_cmd means no command is in progress.
  // ---------------------------------------------------------------------------
  i2cm_pkg::op_e line_cmd;
  logic [4:0]    line_phase;
  logic [7:0]    line_shift;
  logic          line_scl;
  logic          line_sda;
  logic          line_ack;

  // Results still owed by the engine, oldest first.
  i2cm_pkg::result_t bus_result_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned recv_hold_cycles;
  int unsigned err_cnt;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned rejects_seen;
  int unsigned transfers_done;
  int unsigned cmds_taken[6];

  function automatic void clear_line_state();
    line_cmd   = i2cm_pkg::OP_TICK;
    line_phase = '0;
    line_shift = '0;
    line_scl   = 1'b1;
    line_sda   = 1'b1;
    line_ack   = 1'b0;
  endfunction

  // Apply one word to the shadow sequencer and return the result it must produce.
  function automatic i2cm_pkg::result_t bus_step(input logic [2:0] op,
                                                 input logic [7:0] data,
                                                 input logic sda_in);
    i2cm_pkg::result_t res;
    logic              fin;
    logic [4:0]        ph;
    int unsigned       slot;
    res = '0;
    fin = 1'b0;
    if (op >= i2cm_pkg::OP_START && op <= i2cm_pkg::OP_READ_NACK) begin
      if (line_cmd != i2cm_pkg::OP_TICK) begin
        // Command while a sequence runs: drop it, flag it, touch nothing.
        res.rejected = 1'b1;
      end else begin
        // Arm only; the first phase comes with the next tick.
        line_cmd   = i2cm_pkg::op_e'(op);
        line_phase = '0;
        line_shift = (op == i2cm_pkg::OP_WRITE) ? data : 8'h00;
        cmds_taken[op]++;
      end
    end else if (op == i2cm_pkg::OP_TICK && line_cmd != i2cm_pkg::OP_TICK) begin
      ph         = line_phase + 5'd1;
      line_phase = ph;
      case (line_cmd)
        i2cm_pkg::OP_START: begin
          // SDA high, SCL high, SDA low, SCL low.
          case (ph)
            5'd1:    line_sda = 1'b1;
            5'd2:    line_scl = 1'b1;
            5'd3:    line_sda = 1'b0;
            default: begin
              line_scl = 1'b0;
              fin      = 1'b1;
            end
          endcase
        end
        i2cm_pkg::OP_STOP: begin
          // SDA low, SCL high, SDA high.
          case (ph)
            5'd1:    line_sda = 1'b0;
            5'd2:    line_scl = 1'b1;
            default: begin
              line_sda = 1'b1;
              fin      = 1'b1;
            end
          endcase
        end
        i2cm_pkg::OP_WRITE: begin
          if (ph <= 5'd24) begin
            // Three phases per bit: data setup, clock high, clock low.
            slot = (ph - 1) % 3;
            if (slot == 0) begin
              line_sda   = line_shift[7];
              line_shift = {line_shift[6:0], 1'b0};
            end else if (slot == 1) begin
              line_scl = 1'b1;
            end else begin
              line_scl = 1'b0;
            end
          end else if (ph == 5'd25) begin
            line_sda = 1'b1;
          end else if (ph == 5'd26) begin
            line_scl = 1'b1;
          end else begin
            // Slave pulling SDA low during the clock-high phase means ack.
            line_ack = ~sda_in;
            line_scl = 1'b0;
            fin      = 1'b1;
          end
        end
        default: begin
          // Read with ack or nack.
          if (ph == 5'd1) begin
            line_sda = 1'b1;
          end else if (ph <= 5'd18) begin
            if (!ph[0]) begin
              line_scl = 1'b0;
              // Shift in the level seen while the clock was high.
              if (ph >= 5'd4) line_shift = {line_shift[6:0], sda_in};
            end else begin
              line_scl = 1'b1;
            end
          end else if (ph == 5'd19) begin
            line_sda = (line_cmd == i2cm_pkg::OP_READ_ACK) ? 1'b0 : 1'b1;
          end else if (ph == 5'd20) begin
            line_scl = 1'b1;
          end else begin
            line_scl = 1'b0;
            fin      = 1'b1;
          end
        end
      endcase
      if (fin) begin
        res.done_res = 1'b1;
        if (line_cmd == i2cm_pkg::OP_WRITE) res.ack_ok = line_ack;
        if (line_cmd == i2cm_pkg::OP_READ_ACK || line_cmd == i2cm_pkg::OP_READ_NACK) begin
          res.rx_byte = line_shift;
        end
        line_cmd   = i2cm_pkg::OP_TICK;
        line_phase = '0;
      end
    end
    res.scl         = line_scl;
    res.sda_release = line_sda;
    res.busy_res    = (line_cmd != i2cm_pkg::OP_TICK);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Called and returning at a falling edge; valid stays high
  // between words unless an idle gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [2:0] op, input logic [7:0] data, input logic sda_in);
    i2cm_pkg::result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    cmd_ch.valid     = 1'b1;
    cmd_ch.op        = op;
    cmd_ch.data_byte = data;
    cmd_ch.sda_in    = sda_in;
    do @(posedge clk_i); while (!cmd_ch.ready);
    res = bus_step(op, data, sda_in);
    if (res.rejected) rejects_seen++;
    if (res.done_res) transfers_done++;
    bus_result_q.push_back(res);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Tick the running command through to its end.
  task automatic tick_to_idle(input int unsigned sda_src);
    logic bit_in;
    while (line_cmd != i2cm_pkg::OP_TICK) begin
      case (sda_src)
        SDA_LOW:  bit_in = 1'b0;
        SDA_HIGH: bit_in = 1'b1;
        default:  bit_in = 1'($urandom_range(1));
      endcase
      send_word(i2cm_pkg::OP_TICK, 8'($urandom_range(255)), bit_in);
    end
  endtask

  // One random word shaped by the sequencer state: mostly ticks while busy,
  // mostly fresh commands while idle, with some noise either way.
  // Returns 0 for words that the idle engine just ignores.
  task automatic send_random_word(output bit counted);
    int unsigned pick;
    logic [7:0]  data;
    logic [2:0]  op;
    pick    = $urandom_range(99);
    counted = 1'b1;
    case ($urandom_range(3))
      0:       data = 8'h00;
      1:       data = 8'hFF;
      default: data = 8'($urandom_range(255));
    endcase
    if (line_cmd != i2cm_pkg::OP_TICK) begin
      if (pick < 88) begin
        op = i2cm_pkg::OP_TICK;
      end else if (pick < 94) begin
        op = 3'($urandom_range(i2cm_pkg::OP_READ_NACK, i2cm_pkg::OP_START));
      end else begin
        op = 3'($urandom_range(7, 6));
      end
    end else begin
      if (pick < 85) begin
        op = 3'($urandom_range(i2cm_pkg::OP_READ_NACK, i2cm_pkg::OP_START));
      end else begin
        op      = (pick < 92) ? 3'(i2cm_pkg::OP_TICK) : 3'($urandom_range(7, 6));
        counted = 1'b0;
      end
    end
    send_word(op, data, 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready at the falling edge, compare at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (recv_hold_cycles != 0) begin
      res_ch.ready = 1'b0;
      recv_hold_cycles--;
    end else begin
      res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    i2cm_pkg::result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (bus_result_q.size() == 0) begin
        $error("result word with no expectation pending");
        err_cnt++;
      end else begin
        want = bus_result_q.pop_front();
        check_field("scl", want.scl, res_ch.scl);
        check_field("sda_release", want.sda_release, res_ch.sda_release);
        check_field("busy_res", want.busy_res, res_ch.busy_res);
        check_field("done_res", want.done_res, res_ch.done_res);
        check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
        check_field("ack_ok", want.ack_ok, res_ch.ack_ok);
        check_field("rejected", want.rejected, res_ch.rejected);
      end
    end
  end

  // Hang detector: any accepted word on either side restarts the count.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HangLimit) begin
      $display("timeout: no word moved for %0d cycles", HangLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle engine: ticks and spare op codes change nothing.
  task automatic test_idle_words();
    send_word(i2cm_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(i2cm_pkg::OP_TICK, 8'hFF, 1'b1);
    send_word(OP_SPARE6, 8'hFF, 1'b1);
    send_word(OP_SPARE7, 8'h00, 1'b0);
  endtask

  // Start and stop conditions, with rejected and spare words dropped in mid-sequence.
  task automatic test_start_stop();
    send_word(i2cm_pkg::OP_START, 8'h00, 1'b0);
    send_word(i2cm_pkg::OP_TICK, 8'h00, 1'b1);
    send_word(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0);
    send_word(OP_SPARE6, 8'h00, 1'b0);
    tick_to_idle(SDA_RAND);
    send_word(i2cm_pkg::OP_STOP, 8'h00, 1'b0);
    send_word(i2cm_pkg::OP_STOP, 8'hFF, 1'b1);
    send_word(OP_SPARE7, 8'hFF, 1'b1);
    tick_to_idle(SDA_RAND);
  endtask

  // Byte transfers: all-ones write acked, all-zero read nacked, all-ones read acked.
  task automatic test_byte_transfers();
    send_word(i2cm_pkg::OP_WRITE, 8'hFF, 1'b1);
    send_word(i2cm_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(i2cm_pkg::OP_READ_ACK, 8'h00, 1'b0);
    tick_to_idle(SDA_LOW);
    send_word(i2cm_pkg::OP_READ_NACK, 8'hFF, 1'b1);
    tick_to_idle(SDA_LOW);
    send_word(i2cm_pkg::OP_READ_ACK, 8'h00, 1'b0);
    tick_to_idle(SDA_HIGH);
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned sent;
    bit          counted;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_words) begin
      send_random_word(counted);
      if (counted) sent++;
    end
  endtask

  // Hold the result side off for a long stretch while words keep coming, so the
  // queue fills and the engine stalls its input.
  task automatic test_output_backpressure();
    bit counted;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    recv_hold_cycles = LongHold;
    repeat (40) send_random_word(counted);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.op        = i2cm_pkg::OP_TICK;
    cmd_ch.data_byte = 8'h00;
    cmd_ch.sda_in    = 1'b0;
    res_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    recv_hold_cycles = 0;
    err_cnt          = 0;
    words_sent       = 0;
    results_seen     = 0;
    rejects_seen     = 0;
    transfers_done   = 0;
    foreach (cmds_taken[k]) cmds_taken[k] = 0;
    clear_line_state();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_words();
    test_start_stop();
    test_byte_transfers();
    test_random_traffic(155, 0, 0);
    test_random_traffic(155, 55, 0);
    test_output_backpressure();
    test_random_traffic(155, 0, 55);
    test_random_traffic(155, 32, 32);

    // Drain: drop valid and wait for every owed result.
    cmd_ch.valid   = 1'b0;
    recv_stall_pct = 0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d words and %0d results: %0d starts, %0d stops, %0d writes,",
             words_sent, results_seen, cmds_taken[i2cm_pkg::OP_START],
             cmds_taken[i2cm_pkg::OP_STOP], cmds_taken[i2cm_pkg::OP_WRITE]);
    $display("  %0d acked reads, %0d nacked reads, %0d completions, %0d busy rejections.",
             cmds_taken[i2cm_pkg::OP_READ_ACK], cmds_taken[i2cm_pkg::OP_READ_NACK],
             transfers_done, rejects_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_byte_engine.sv
sv/i2cm_checker.sv
sim/tb_i2c_master_byte_engine.sv
